/* hdl/twcp_pkg.sv */
// ----------------------------------------------------------------------------
// twcp_pkg
// shared types and constants for the three-way colour partition core
// ----------------------------------------------------------------------------
package twcp_pkg;

  // colour codes, any code above red is folded onto red
  localparam logic [1:0] COL_BLUE  = 2'd0;
  localparam logic [1:0] COL_GREEN = 2'd1;
  localparam logic [1:0] COL_RED   = 2'd2;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 7;

  // one stored entry
  typedef struct packed {
    logic [1:0]         color;
    logic [VALUE_W-1:0] value;
  } item_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_PRD,
    S_PEVAL,
    S_PW1,
    S_PW2,
    S_EMIT,
    S_DONE
  } state_t;

endpackage

/* hdl/three_way_color_partition_core.sv */
// ----------------------------------------------------------------------------
// three_way_color_partition_core
// loads colour-tagged items into a buffer, runs a three-index partition in
// place and streams the reordered set out with the group boundaries
// ----------------------------------------------------------------------------
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+-------------------------
//  input    | in_color in_value in_last_in            | start high, busy low
//  result   | out_color out_value out_blue_count      | out_valid, one cycle,
//           | out_green_end out_overflow out_last_out | no back-pressure
//
//  loading takes one cycle per beat; the set ends on the beat with in_last_in
//  partition: each green item passes S_PRD and S_PEVAL, a blue or red swap
//  also S_PW1 and S_PW2, as every swap needs two reads and two writes
//  emission: one beat per cycle from the registered read port, then S_DONE
//  clears the indices; busy stays high from the last beat until then
//  synchronous active-low reset clears counters, indices and the flag;
//  the buffer itself holds no reset and is only read where written this set
//  the receiver cannot stall, so results leave at the buffer read rate
//
module three_way_color_partition_core #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_color,
  input  logic signed [31:0]             in_value,
  input  logic                           in_last_in,
  output logic                           out_valid,
  output logic [1:0]                     out_color,
  output logic signed [31:0]             out_value,
  output logic [twcp_pkg::COUNT_W-1:0]   out_blue_count,
  output logic [twcp_pkg::COUNT_W-1:0]   out_green_end,
  output logic                           out_overflow,
  output logic                           out_last_out
);
  import twcp_pkg::*;

  // count width holds DEPTH itself, address width indexes the buffer
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = $clog2(DEPTH);

  // item buffer, one write and one registered read port
  item_t mem [DEPTH];

  state_t         state_r, state_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [CW-1:0]  scan_r, scan_nxt;
  logic [CW-1:0]  blue_r, blue_nxt;
  logic [CW-1:0]  red_r, red_nxt;
  logic [CW-1:0]  emit_r, emit_nxt;
  logic           dropped_r, dropped_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           out_last_r, out_last_nxt;
  logic [AW-1:0]  swap_a_r, swap_a_nxt;
  logic [AW-1:0]  swap_b_r, swap_b_nxt;
  item_t          cur_r, cur_nxt;
  item_t          rdata_r;

  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  item_t          wr_data;

  logic           accept;
  logic           has_room;
  logic [1:0]     in_color_fold;

  // only the load state takes input beats
  assign busy          = (state_r != S_LOAD);
  assign accept        = start && !busy;
  assign has_room      = count_r < CW'(DEPTH);
  assign in_color_fold = in_color[1] ? COL_RED : in_color;

  // buffer write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // buffer read port, data registered and held while not reading
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD: begin
        if (accept && in_last_in) begin
          state_nxt = S_PRD;
        end
      end
      S_PRD: begin
        // scan meets the red boundary: partition is complete
        state_nxt = (scan_r < red_r) ? S_PEVAL : S_EMIT;
      end
      S_PEVAL: begin
        state_nxt = (rdata_r.color == COL_GREEN) ? S_PRD : S_PW1;
      end
      S_PW1: state_nxt = S_PW2;
      S_PW2: state_nxt = S_PRD;
      S_EMIT: begin
        if (emit_r + CW'(1) >= count_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: state_nxt = S_LOAD;
      default: state_nxt = S_LOAD;
    endcase
  end

  // datapath control and register next values
  always_comb begin
    rd_en         = 1'b0;
    rd_addr       = scan_r[AW-1:0];
    wr_en         = 1'b0;
    wr_addr       = count_r[AW-1:0];
    wr_data       = '{color: in_color_fold, value: in_value};
    count_nxt     = count_r;
    scan_nxt      = scan_r;
    blue_nxt      = blue_r;
    red_nxt       = red_r;
    emit_nxt      = emit_r;
    dropped_nxt   = dropped_r;
    out_valid_nxt = 1'b0;
    out_last_nxt  = 1'b0;
    swap_a_nxt    = swap_a_r;
    swap_b_nxt    = swap_b_r;
    cur_nxt       = cur_r;
    case (state_r)
      S_LOAD: begin
        if (accept) begin
          if (has_room) begin
            wr_en     = 1'b1;
            count_nxt = count_r + CW'(1);
          end else begin
            dropped_nxt = 1'b1;
          end
          if (in_last_in) begin
            scan_nxt = '0;
            blue_nxt = '0;
            emit_nxt = '0;
            red_nxt  = has_room ? count_r + CW'(1) : count_r;
          end
        end
      end
      S_PRD: begin
        // fetch the item under the scan index
        rd_en   = scan_r < red_r;
        rd_addr = scan_r[AW-1:0];
      end
      S_PEVAL: begin
        cur_nxt    = rdata_r;
        swap_a_nxt = scan_r[AW-1:0];
        if (rdata_r.color == COL_GREEN) begin
          scan_nxt = scan_r + CW'(1);
        end else if (rdata_r.color == COL_BLUE) begin
          // swap with the first green item at the blue boundary
          rd_en      = 1'b1;
          rd_addr    = blue_r[AW-1:0];
          swap_b_nxt = blue_r[AW-1:0];
          blue_nxt   = blue_r + CW'(1);
          scan_nxt   = scan_r + CW'(1);
        end else begin
          // swap with the last unscanned item, red boundary moves down
          rd_en      = 1'b1;
          red_nxt    = red_r - CW'(1);
          rd_addr    = red_nxt[AW-1:0];
          swap_b_nxt = red_nxt[AW-1:0];
        end
      end
      S_PW1: begin
        // partner item into the scan slot
        wr_en   = 1'b1;
        wr_addr = swap_a_r;
        wr_data = rdata_r;
      end
      S_PW2: begin
        // scanned item into the partner slot
        wr_en   = 1'b1;
        wr_addr = swap_b_r;
        wr_data = cur_r;
      end
      S_EMIT: begin
        if (emit_r < count_r) begin
          rd_en         = 1'b1;
          rd_addr       = emit_r[AW-1:0];
          out_valid_nxt = 1'b1;
          out_last_nxt  = (emit_r + CW'(1)) == count_r;
          emit_nxt      = emit_r + CW'(1);
        end
      end
      S_DONE: begin
        // final beat is on the ports this cycle; clear for the next set
        count_nxt   = '0;
        scan_nxt    = '0;
        blue_nxt    = '0;
        red_nxt     = '0;
        emit_nxt    = '0;
        dropped_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      scan_r      <= '0;
      blue_r      <= '0;
      red_r       <= '0;
      emit_r      <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      scan_r      <= scan_nxt;
      blue_r      <= blue_nxt;
      red_r       <= red_nxt;
      emit_r      <= emit_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  // swap payload registers
  always_ff @(posedge clk) begin
    swap_a_r <= swap_a_nxt;
    swap_b_r <= swap_b_nxt;
    cur_r    <= cur_nxt;
  end

  // result beat, boundaries masked to the port width
  assign out_valid      = out_valid_r;
  assign out_color      = rdata_r.color;
  assign out_value      = $signed(rdata_r.value);
  assign out_blue_count = COUNT_W'(blue_r);
  assign out_green_end  = COUNT_W'(red_r);
  assign out_overflow   = dropped_r;
  assign out_last_out   = out_last_r;

  // results only leave while the block is occupied
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> busy)
    else $error("result beat while idle");

  // the set closes on a last beat and the block turns busy
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_last_in) |=> busy)
    else $error("last beat did not start the partition");

  // the blue boundary never overtakes the scan index
  assert property (@(posedge clk) disable iff (!rst_n) blue_r <= scan_r)
    else $error("blue boundary ahead of scan index");

  // an item is only evaluated below the red boundary
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PEVAL) |-> (scan_r < red_r))
    else $error("evaluation past the red boundary");

  // the last beat of a non-empty set is always flagged with a valid strobe
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && count_r != '0) |-> (out_valid && out_last_out))
    else $error("set ended without a last result beat");

endmodule
